>>> rtl/core/mipd_pkg.sv
// Shared constants and types for the minimum-image pair distance core.
`timescale 1ns / 1ps

package mipd_pkg;

	// Default coordinate width in bits (signed fixed point).
	localparam int COORD_WIDTH_DEF = 32;

	// Register stages inside each datapath unit.
	localparam int AXIS_STAGES   = 3;
	localparam int SQUARE_STAGES = 2;
	localparam int SUM_STAGES    = 1;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PERIODIC = 2'd0,
		CFG_BOX_X    = 2'd1,
		CFG_BOX_Y    = 2'd2,
		CFG_BOX_Z    = 2'd3
	} cfg_idx_t;

endpackage

>>> rtl/core/mipd_axis.sv
// Per-axis difference, magnitude and minimum-image fold, three register stages.
`timescale 1ns / 1ps

module mipd_axis #(
	parameter int COORD_WIDTH = mipd_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic                          periodic,
	input  logic [COORD_WIDTH-2:0]        box_len,
	input  logic signed [COORD_WIDTH-1:0] coord_a,
	input  logic signed [COORD_WIDTH-1:0] coord_b,
	output logic [COORD_WIDTH:0]          mag
);

	localparam int W = COORD_WIDTH;

	logic signed [W:0] diff_s1;
	logic signed [W:0] diff_neg;
	logic [W:0]        mag_s2;
	logic [W:0]        len_ext;
	logic [W+1:0]      mag_twice;
	logic              fold;
	logic [W:0]        folded;
	logic [W:0]        mag_s3;

	assign diff_neg  = -diff_s1;
	assign len_ext   = {2'b00, box_len};
	assign mag_twice = {mag_s2, 1'b0};
	assign fold      = periodic && (mag_twice > {1'b0, len_ext});
	assign folded    = (len_ext >= mag_s2) ? (len_ext - mag_s2) : (mag_s2 - len_ext);

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s1 <= {coord_a[W-1], coord_a} - {coord_b[W-1], coord_b};
			mag_s2  <= diff_s1[W] ? diff_neg : diff_s1;
			mag_s3  <= fold ? folded : mag_s2;
		end
	end

	assign mag = mag_s3;

endmodule

>>> rtl/core/mipd_square.sv
// Squarer built from three half-width partial products, two register stages.
`timescale 1ns / 1ps

module mipd_square #(
	parameter int COORD_WIDTH = mipd_pkg::COORD_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [COORD_WIDTH:0]       mag,
	output logic [2*COORD_WIDTH+1:0]   sq
);

	localparam int M = COORD_WIDTH + 1;
	localparam int K = (M + 1) / 2;
	localparam int H = M - K;

	logic [H-1:0]     mag_hi;
	logic [K-1:0]     mag_lo;
	logic [2*H-1:0]   hh;
	logic [H+K-1:0]   hl;
	logic [2*K-1:0]   ll;
	logic [2*H-1:0]   hh_s1;
	logic [H+K-1:0]   hl_s1;
	logic [2*K-1:0]   ll_s1;
	logic [2*M-1:0]   sq_s2;

	assign mag_hi = mag[M-1:K];
	assign mag_lo = mag[K-1:0];
	assign hh = {{H{1'b0}}, mag_hi} * {{H{1'b0}}, mag_hi};
	assign hl = {{K{1'b0}}, mag_hi} * {{H{1'b0}}, mag_lo};
	assign ll = {{K{1'b0}}, mag_lo} * {{K{1'b0}}, mag_lo};

	// (h*2^K + l)^2 = h^2*2^2K + 2hl*2^K + l^2
	always_ff @(posedge clk) begin
		if (en) begin
			hh_s1 <= hh;
			hl_s1 <= hl;
			ll_s1 <= ll;
			sq_s2 <= {hh_s1, {(2*K){1'b0}}}
				+ {{(2*M-(H+2*K+1)){1'b0}}, hl_s1, {(K+1){1'b0}}}
				+ {{(2*H){1'b0}}, ll_s1};
		end
	end

	assign sq = sq_s2;

endmodule

>>> rtl/core/mipd_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
`timescale 1ns / 1ps

module mipd_isqrt #(
	parameter int COORD_WIDTH = mipd_pkg::COORD_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [2*COORD_WIDTH+1:0]   rad,
	output logic [COORD_WIDTH:0]       root
);

	localparam int R  = COORD_WIDTH + 1;
	localparam int NW = 2 * R;

	// Stage j holds the partial root after j+1 bits; all but the last stage also hold the remainder and the radicand.
	logic [R-1:0]  root_s [R];
	logic [R:0]    rem_s  [R-1];
	logic [NW-1:0] rad_s  [R-1];

	for (genvar j = 0; j < R; j++) begin : g_step
		logic [R-1:0]  r_in;
		logic [R:0]    rem_in;
		logic [NW-1:0] rad_in;
		logic [R+2:0]  shifted;
		logic [R+2:0]  trial;
		logic [R+2:0]  rem_sub;
		logic          fits;

		if (j == 0) begin : g_first
			assign r_in   = '0;
			assign rem_in = '0;
			assign rad_in = rad;
		end else begin : g_next
			assign r_in   = root_s[j-1];
			assign rem_in = rem_s[j-1];
			assign rad_in = rad_s[j-1];
		end

		assign shifted = {rem_in, rad_in[2*(R-1-j)+1 -: 2]};
		assign trial   = {1'b0, r_in, 2'b01};
		assign fits    = shifted >= trial;
		assign rem_sub = shifted - trial;

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[j] <= {r_in[R-2:0], fits};
			end
		end

		if (j < R - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rad_s[j] <= rad_in;
					rem_s[j] <= fits ? rem_sub[R:0] : shifted[R:0];
				end
			end
		end
	end

	assign root = root_s[R-1];

endmodule

>>> rtl/core/min_image_pair_distance_core.sv
// Top level of the minimum-image pair distance core.
`timescale 1ns / 1ps

// Usage:
// The input channel carries one particle pair per transaction (first_* and
// second_* coordinates, signed fixed point). A transaction completes on a
// rising edge with in_valid high and in_stall low. The output channel returns
// one distance per pair, in order, under the same valid/stall rule.
// Throughput is one pair per cycle while in_stall is low. An input
// transaction reaches out_valid through three stages per axis for
// difference, magnitude and fold, two for the squarer, one for the sum of
// squares, one per result bit in the square root and the output register.
// Configuration is written through cfg_valid/cfg_ready (always ready) with
// cfg_index selecting periodic mode or a box length; write it only while no
// pair is in flight. Reset clears the configuration to zero and empties the
// pipeline. When the receiver stalls, the output register holds its result
// and one more result lands in a skid register; the pipeline then freezes and
// in_stall rises until the skid entry drains. in_stall is a register output.
module min_image_pair_distance_core #(
	parameter int COORD_WIDTH = mipd_pkg::COORD_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,

	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mipd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [COORD_WIDTH-2:0]               cfg_data,

	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [COORD_WIDTH-1:0]        first_x,
	input  logic signed [COORD_WIDTH-1:0]        first_y,
	input  logic signed [COORD_WIDTH-1:0]        first_z,
	input  logic signed [COORD_WIDTH-1:0]        second_x,
	input  logic signed [COORD_WIDTH-1:0]        second_y,
	input  logic signed [COORD_WIDTH-1:0]        second_z,

	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [COORD_WIDTH:0]                 distance
);

	localparam int W     = COORD_WIDTH;
	localparam int OUT_W = W + 1;
	localparam int SQ_W  = 2 * W + 2;
	localparam int LAT   = mipd_pkg::AXIS_STAGES + mipd_pkg::SQUARE_STAGES
		+ mipd_pkg::SUM_STAGES + OUT_W;

	// Configuration registers.
	logic         periodic_q;
	logic [W-2:0] box_x_q;
	logic [W-2:0] box_y_q;
	logic [W-2:0] box_z_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			periodic_q <= 1'b0;
			box_x_q    <= '0;
			box_y_q    <= '0;
			box_z_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (mipd_pkg::cfg_idx_t'(cfg_index))
				mipd_pkg::CFG_PERIODIC: periodic_q <= cfg_data[0];
				mipd_pkg::CFG_BOX_X:    box_x_q    <= cfg_data;
				mipd_pkg::CFG_BOX_Y:    box_y_q    <= cfg_data;
				mipd_pkg::CFG_BOX_Z:    box_z_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The whole pipeline advances together unless the skid register is full.
	logic skid_valid_q;
	logic en;

	assign en       = !skid_valid_q;
	assign in_stall = skid_valid_q;

	// Valid bits travel alongside the data, one per stage.
	logic [LAT-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// Per-axis fold and square.
	logic [W:0]      mag_x, mag_y, mag_z;
	logic [SQ_W-1:0] sq_x, sq_y, sq_z;

	mipd_axis #(.COORD_WIDTH(W)) u_axis_x (
		.clk(clk), .en(en), .periodic(periodic_q), .box_len(box_x_q),
		.coord_a(first_x), .coord_b(second_x), .mag(mag_x)
	);
	mipd_axis #(.COORD_WIDTH(W)) u_axis_y (
		.clk(clk), .en(en), .periodic(periodic_q), .box_len(box_y_q),
		.coord_a(first_y), .coord_b(second_y), .mag(mag_y)
	);
	mipd_axis #(.COORD_WIDTH(W)) u_axis_z (
		.clk(clk), .en(en), .periodic(periodic_q), .box_len(box_z_q),
		.coord_a(first_z), .coord_b(second_z), .mag(mag_z)
	);

	mipd_square #(.COORD_WIDTH(W)) u_sq_x (.clk(clk), .en(en), .mag(mag_x), .sq(sq_x));
	mipd_square #(.COORD_WIDTH(W)) u_sq_y (.clk(clk), .en(en), .mag(mag_y), .sq(sq_y));
	mipd_square #(.COORD_WIDTH(W)) u_sq_z (.clk(clk), .en(en), .mag(mag_z), .sq(sq_z));

	// Sum of squares. Each square is below 2^(2W), so three fit in 2W+2 bits.
	logic [SQ_W-1:0] sum_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s6 <= sq_x + sq_y + sq_z;
		end
	end

	logic [OUT_W-1:0] root;

	mipd_isqrt #(.COORD_WIDTH(W)) u_isqrt (
		.clk(clk), .en(en), .rad(sum_s6), .root(root)
	);

	// Output register with one skid entry behind it.
	logic             out_valid_q;
	logic             last_vld;
	logic             out_free;
	logic [OUT_W-1:0] distance_q;
	logic [OUT_W-1:0] skid_q;

	assign last_vld = vld_q[LAT-1];
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= en && last_vld;
			end
		end else if (en && last_vld) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			distance_q <= skid_valid_q ? skid_q : root;
		end else if (en && last_vld) begin
			skid_q <= root;
		end
	end

	assign out_valid = out_valid_q;
	assign distance  = distance_q;

`ifndef SYNTHESIS
	// A skid entry only exists behind a result still held in the output register.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register full while output register empty");

	// The skid register fills only when a result arrives at a stalled output.
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !$past(skid_valid_q)) |->
			$past(last_vld && out_valid_q && out_stall))
		else $error("skid register filled without a stalled result");

	// Every accepted input transaction enters the first stage.
	a_input_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld_q[0])
		else $error("accepted input transaction missing from first stage");
`endif

endmodule
